/* rtl/rational_arithmetic_unit_defines.svh */
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RAU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rational arithmetic unit assertion failed");

// Check that cons holds in the cycle after ante.
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rational arithmetic unit assertion failed");

`endif

/* rtl/rau_pkg.sv */
// Shared types and codes of the rational arithmetic unit.
package rau_pkg;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } rau_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_OUT
    } rau_state_t;

    typedef struct packed {
        logic reduce;
        logic is_less;
        logic is_equal;
        logic is_greater;
        logic invalid;
    } rau_tag_t;

    localparam int TAG_BITS = 5;

endpackage

/* rtl/rau_front.sv */
// Front end: accepts items, forms cross products and classifies the result.
module rau_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 in_mode,
    input  logic [FRAC_BITS-1:0]       in_an,
    input  logic [FRAC_BITS-1:0]       in_ad,
    input  logic [FRAC_BITS-1:0]       in_bn,
    input  logic [FRAC_BITS-1:0]       in_bd,
    input  logic [FRAC_BITS-1:0]       in_sc,
    output logic                       push,
    input  logic                       push_ready,
    output rau_pkg::rau_tag_t          push_tag,
    output logic [2*FRAC_BITS:0]       push_num,
    output logic [2*FRAC_BITS-1:0]     push_den
);
    localparam int PW = 2 * FRAC_BITS;
    localparam int NW = PW + 1;

    logic                 valid_reg, valid_next;
    logic [2:0]           mode_reg;
    logic [FRAC_BITS-1:0] an_reg, ad_reg;
    logic                 dzero_reg;
    logic [PW-1:0]        p1_reg, p2_reg, p3_reg;
    logic                 accept;
    logic [FRAC_BITS-1:0] m1_b, m3_b;
    logic [NW-1:0]        num;
    logic [PW-1:0]        den;
    logic                 bad;
    rau_pkg::rau_tag_t    tag;

    assign in_ready = !valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign push     = valid_reg && push_ready;
    assign m1_b     = (in_mode == rau_pkg::MODE_MUL) ? in_sc : in_bd;
    assign m3_b     = (in_mode == rau_pkg::MODE_DIV) ? in_sc : in_bd;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= in_mode;
            an_reg    <= in_an;
            ad_reg    <= in_ad;
            dzero_reg <= (in_ad == '0) || (in_bd == '0);
            p1_reg    <= in_an * m1_b;
            p2_reg    <= in_bn * in_ad;
            p3_reg    <= in_ad * m3_b;
        end
    end

    always_comb begin
        num = '0;
        den = '0;
        bad = 1'b0;
        tag = '0;
        unique case (mode_reg)
            rau_pkg::MODE_ADD: begin
                num = NW'(p1_reg) + NW'(p2_reg);
                den = p3_reg;
            end
            rau_pkg::MODE_SUB: begin
                bad = p1_reg < p2_reg;
                num = NW'(p1_reg - p2_reg);
                den = p3_reg;
            end
            rau_pkg::MODE_MUL: begin
                num = NW'(p1_reg);
                den = PW'(ad_reg);
            end
            rau_pkg::MODE_DIV: begin
                num = NW'(an_reg);
                den = p3_reg;
            end
            rau_pkg::MODE_CMP: begin
                bad = dzero_reg;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (mode_reg == rau_pkg::MODE_CMP) begin
            tag.invalid    = bad;
            tag.is_less    = !bad && (p1_reg < p2_reg);
            tag.is_equal   = !bad && (p1_reg == p2_reg);
            tag.is_greater = !bad && (p1_reg > p2_reg);
        end else begin
            tag.invalid = bad || (den == '0);
            tag.reduce  = !tag.invalid;
        end
        if (!tag.reduce) begin
            num = '0;
            den = '0;
        end
    end

    assign push_tag = tag;
    assign push_num = num;
    assign push_den = den;
endmodule

/* rtl/rau_queue.sv */
// Two-entry queue between the front and back ends.
module rau_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             wr, rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_pop && rd_valid;
    assign rd_data  = mem[rptr_reg];

    always_comb begin
        wptr_next  = wr ? !wptr_reg : wptr_reg;
        rptr_next  = rd ? !rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wptr_reg] <= wr_data;
        end
    end
endmodule

/* rtl/rau_back.sv */
// Back end: binary gcd, reduction by restoring division and the result register.
module rau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  rau_pkg::rau_tag_t      q_tag,
    input  logic [2*FRAC_BITS:0]   q_num,
    input  logic [2*FRAC_BITS-1:0] q_den,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [32:0]            out_beat,
    output logic [31:0]            out_sub,
    output rau_pkg::rau_tag_t      out_tag
);
    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    rau_pkg::rau_state_t state_reg, state_next;
    logic [NW-1:0]       u_reg, v_reg, nq_reg, dq_reg, g_reg, rn_reg, rd_reg;
    logic [CW-1:0]       cnt_reg;
    rau_pkg::rau_tag_t   tag_reg;
    logic                gcd_done, div_done;
    logic                load, step_gcd, step_div;
    logic [NW:0]         tn, td;
    logic                gen, ged;

    assign gcd_done = (u_reg == '0) || (v_reg == '0);
    assign div_done = cnt_reg == CW'(NW - 1);
    assign tn  = {rn_reg, nq_reg[NW-1]};
    assign td  = {rd_reg, dq_reg[NW-1]};
    assign gen = tn >= {1'b0, g_reg};
    assign ged = td >= {1'b0, g_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_tag.reduce ? rau_pkg::ST_GCD : rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_GCD: begin
                if (gcd_done) begin
                    state_next = rau_pkg::ST_DIV;
                end
            end
            rau_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT: begin
                if (out_ready) begin
                    state_next = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        load      = 1'b0;
        step_gcd  = 1'b0;
        step_div  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            rau_pkg::ST_IDLE: load      = q_valid;
            rau_pkg::ST_GCD:  step_gcd  = 1'b1;
            rau_pkg::ST_DIV:  step_div  = 1'b1;
            rau_pkg::ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tag_reg <= q_tag;
            u_reg   <= NW'(q_den);
            v_reg   <= q_num;
            nq_reg  <= q_num;
            dq_reg  <= NW'(q_den);
            rn_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else if (step_gcd) begin
            if (gcd_done) begin
                g_reg <= u_reg | v_reg;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_reg  <= u_reg >> 1;
                v_reg  <= v_reg >> 1;
                nq_reg <= nq_reg >> 1;
                dq_reg <= dq_reg >> 1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_reg <= (u_reg - v_reg) >> 1;
            end else begin
                v_reg <= (v_reg - u_reg) >> 1;
            end
        end else if (step_div) begin
            rn_reg  <= NW'(gen ? tn - {1'b0, g_reg} : tn);
            rd_reg  <= NW'(ged ? td - {1'b0, g_reg} : td);
            nq_reg  <= {nq_reg[NW-2:0], gen};
            dq_reg  <= {dq_reg[NW-2:0], ged};
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    assign out_tag  = tag_reg;
    assign out_beat = tag_reg.reduce ? 33'(nq_reg) : '0;
    assign out_sub  = tag_reg.reduce ? 32'(dq_reg) : '0;
endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit.
// Channel | Dir | tdata                                         | tuser
// s_      | in  | a_beat, a_sub, b_beat, b_sub, scalar (16 ea.) | mode [2:0]
// m_      | out | result_beat [32:0], result_sub [64:33]        | less, equal, greater, invalid
// Front end: a registered multiply stage, then classification into a two-entry queue.
// Back end: binary gcd, then restoring division of both terms by the gcd;
// compare and invalid items skip both.
// Reset clears the stage valid, queue count and back-end state.
// A stalled result holds the back end; the queue lets the front keep accepting until it fills.
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // a_beat, a_sub, b_beat, b_sub, scalar
    input  logic [2:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // result_beat, result_sub, zero pad
    output logic [3:0]  m_tuser    // is_less, is_equal, is_greater, invalid
);
    localparam int PW = 2 * FRAC_BITS;
    localparam int NW = PW + 1;
    localparam int QW = rau_pkg::TAG_BITS + NW + PW;

    logic              push, push_ready;
    rau_pkg::rau_tag_t push_tag, q_tag, out_tag;
    logic [NW-1:0]     push_num;
    logic [PW-1:0]     push_den;
    logic [QW-1:0]     q_data;
    logic              q_valid, q_pop;
    logic [32:0]       out_beat;
    logic [31:0]       out_sub;

    rau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_an      (FRAC_BITS'(s_tdata[15:0])),
        .in_ad      (FRAC_BITS'(s_tdata[31:16])),
        .in_bn      (FRAC_BITS'(s_tdata[47:32])),
        .in_bd      (FRAC_BITS'(s_tdata[63:48])),
        .in_sc      (FRAC_BITS'(s_tdata[79:64])),
        .push       (push),
        .push_ready (push_ready),
        .push_tag   (push_tag),
        .push_num   (push_num),
        .push_den   (push_den)
    );

    rau_queue #(.WIDTH(QW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_data  ({push_tag, push_num, push_den}),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    assign q_tag = q_data[QW-1 -: rau_pkg::TAG_BITS];

    rau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_tag     (q_tag),
        .q_num     (q_data[PW +: NW]),
        .q_den     (q_data[PW-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .out_sub   (out_sub),
        .out_tag   (out_tag)
    );

    assign m_tdata = {7'd0, out_sub, out_beat};
    assign m_tuser = {out_tag.invalid, out_tag.is_greater, out_tag.is_equal, out_tag.is_less};

    `RAU_ASSERT_NOW(a_flags_onehot, aclk, aresetn, m_tvalid, $onehot0(m_tuser))
    `RAU_ASSERT_NOW(a_flag_zero_data, aclk, aresetn, m_tvalid && (m_tuser != 4'd0), m_tdata == 72'd0)
    `RAU_ASSERT_NOW(a_reduced_den, aclk, aresetn, m_tvalid && (m_tuser == 4'd0), m_tdata[64:33] != 32'd0)
    `RAU_ASSERT_NEXT(a_no_pop_while_out, aclk, aresetn, m_tvalid && !m_tready, !$past(q_pop))
endmodule

/* sim/rau_checker.sv */
// Checker for the rational arithmetic unit: predicts each result and compares it.
module rau_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic [32:0] beat;
        logic [31:0] sub;
        logic        less;
        logic        equal;
        logic        greater;
        logic        invalid;
    } rau_result_t;

    rau_result_t expected_results[$];

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic rau_result_t reduce_fraction(logic [2:0] mode, logic [79:0] d);
        rau_result_t r;
        logic [63:0] an, ad, bn, bd, sc, num, den, lhs, rhs, g;
        logic bad;
        r = '0;
        an = 64'(d[15:0]);
        ad = 64'(d[31:16]);
        bn = 64'(d[47:32]);
        bd = 64'(d[63:48]);
        sc = 64'(d[79:64]);
        lhs = an * bd;
        rhs = bn * ad;
        num = 0;
        den = 0;
        bad = 1'b0;
        unique case (mode)
            rau_pkg::MODE_ADD: begin
                num = lhs + rhs;
                den = ad * bd;
            end
            rau_pkg::MODE_SUB: begin
                if (lhs < rhs) bad = 1'b1;
                else num = lhs - rhs;
                den = ad * bd;
            end
            rau_pkg::MODE_MUL: begin
                num = an * sc;
                den = ad;
            end
            rau_pkg::MODE_DIV: begin
                num = an;
                den = ad * sc;
            end
            rau_pkg::MODE_CMP: begin
                if (ad == 0 || bd == 0) begin
                    r.invalid = 1'b1;
                end else begin
                    r.less = lhs < rhs;
                    r.equal = lhs == rhs;
                    r.greater = lhs > rhs;
                end
                return r;
            end
            default: bad = 1'b1;
        endcase
        if (bad || den == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        g = euclid_gcd(den, num);
        r.beat = 33'(num / g);
        r.sub = 32'(den / g);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        rau_result_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.push_back(reduce_fraction(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got.beat = m_tdata[32:0];
                got.sub = m_tdata[64:33];
                {got.invalid, got.greater, got.equal, got.less} = m_tuser;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", 64'd0, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.beat != want.beat)
                        report_mismatch("beat", 64'(got.beat), 64'(want.beat));
                    if (got.sub != want.sub)
                        report_mismatch("sub", 64'(got.sub), 64'(want.sub));
                    if (got.less != want.less)
                        report_mismatch("less", 64'(got.less), 64'(want.less));
                    if (got.equal != want.equal)
                        report_mismatch("equal", 64'(got.equal), 64'(want.equal));
                    if (got.greater != want.greater)
                        report_mismatch("greater", 64'(got.greater), 64'(want.greater));
                    if (got.invalid != want.invalid)
                        report_mismatch("invalid", 64'(got.invalid), 64'(want.invalid));
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule

/* sim/tb_rational_arithmetic_unit.sv */
// Testbench top for the rational arithmetic unit: stimulus, back pressure and verdict.
module tb_rational_arithmetic_unit;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [3:0]  m_tuser;
    int          fail_count;
    int          pending_count;
    bit          sender_busy_mode = 1'b0;

    always #1 aclk = ~aclk;

    rational_arithmetic_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rau_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 16));
            3: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic [2:0] mode, logic [15:0] an, logic [15:0] ad,
                             logic [15:0] bn, logic [15:0] bd, logic [15:0] sc);
        while (sender_busy_mode && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {sc, bd, bn, ad, an};
        s_tuser <= mode;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Receiver: long hold-off, then random stalls with a quiet stretch.
    initial begin
        int cyc;
        cyc = 0;
        @(posedge aresetn);
        repeat (600) @(negedge aclk);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc > 20000 && cyc < 40000) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 99) >= 25);
        end
    end

    initial begin
        logic [2:0] mode;
        logic [15:0] an, ad, bn, bd, sc, k;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed
        send_item(rau_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'd0);
        send_item(rau_pkg::MODE_ADD, 16'd0, 16'd7, 16'd0, 16'd3, 16'd0);
        send_item(rau_pkg::MODE_ADD, 16'd1, 16'd2, 16'd1, 16'd2, 16'd0);
        send_item(rau_pkg::MODE_ADD, 16'd1, 16'd0, 16'd1, 16'd3, 16'd0);
        send_item(rau_pkg::MODE_SUB, 16'd1, 16'd3, 16'd1, 16'd2, 16'd0);
        send_item(rau_pkg::MODE_SUB, 16'd3, 16'd4, 16'd1, 16'd4, 16'd0);
        send_item(rau_pkg::MODE_SUB, 16'd5, 16'd5, 16'd5, 16'd5, 16'd0);
        send_item(rau_pkg::MODE_SUB, 16'd5, 16'd5, 16'd5, 16'd0, 16'd0);
        send_item(rau_pkg::MODE_MUL, 16'hFFFF, 16'd1, 16'd0, 16'd1, 16'hFFFF);
        send_item(rau_pkg::MODE_MUL, 16'd4, 16'd6, 16'd0, 16'd1, 16'd0);
        send_item(rau_pkg::MODE_MUL, 16'd4, 16'd0, 16'd0, 16'd1, 16'd2);
        send_item(rau_pkg::MODE_DIV, 16'd6, 16'd4, 16'd0, 16'd1, 16'd3);
        send_item(rau_pkg::MODE_DIV, 16'd6, 16'd4, 16'd0, 16'd1, 16'd0);
        send_item(rau_pkg::MODE_DIV, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
        send_item(rau_pkg::MODE_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 16'd0);
        send_item(rau_pkg::MODE_CMP, 16'd1, 16'd3, 16'd1, 16'd2, 16'd0);
        send_item(rau_pkg::MODE_CMP, 16'd2, 16'd3, 16'd1, 16'd2, 16'd0);
        send_item(rau_pkg::MODE_CMP, 16'd2, 16'd0, 16'd1, 16'd2, 16'd0);
        send_item(rau_pkg::MODE_CMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(3'd5, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(3'd6, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sender_busy_mode = 1'b1;
        // random
        for (int i = 0; i < 2000; i++) begin
            mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
            an = pick_value();
            ad = pick_value();
            bn = pick_value();
            bd = pick_value();
            sc = pick_value();
            if ($urandom_range(0, 9) != 0) begin
                if (ad == 0) ad = 16'd1;
                if (bd == 0) bd = 16'd1;
            end
            if ($urandom_range(0, 7) == 0) begin
                // share a common factor so the reduction does real work
                k = 16'($urandom_range(2, 12));
                an = an % 4096 * k;
                ad = (ad % 4096 + 1) * k;
            end
            send_item(mode, an, ad, bn, bd, sc);
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
